// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the buddy frame allocator: channel words,
// result codes, register indexes, datapath commands and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

	// Configuration port geometry.
	localparam int unsigned PADDR_W           = 3;
	localparam int unsigned FRAME_BYTES_W     = 17;
	localparam logic [FRAME_BYTES_W-1:0] FRAME_BYTES_RESET = 17'd4096;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Result codes.
	typedef enum logic [2:0] {
		ST_ALLOCATED   = 3'd0,
		ST_FREED       = 3'd1,
		ST_NO_FREE     = 3'd2,
		ST_TOO_LARGE   = 3'd3,
		ST_BAD_ADDRESS = 3'd4
	} status_t;

	// Register indexes on the configuration port.
	typedef enum logic {
		REG_BASE_ADDRESS = 1'b0,
		REG_FRAME_BYTES  = 1'b1
	} reg_idx_t;

	// Request word.
	typedef struct packed {
		logic        kind;
		logic [15:0] frames_wanted;
		logic [31:0] free_address;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic [31:0] block_address;
		logic [9:0]  frame_index;
		logic [2:0]  status;
	} out_word_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR_STEP,
		DP_LOAD,
		DP_SCAN_STEP,
		DP_SPLIT_STEP,
		DP_MARK,
		DP_DIV_STEP,
		DP_PAGE_READ,
		DP_PAGE_TAKE,
		DP_BUDDY_READ,
		DP_MERGE,
		DP_FREE_WRITE,
		DP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic too_large;
		logic clear_done;
		logic scan_hit;
		logic scan_empty;
		logic split_done;
		logic div_last;
		logic div_bad;
		logic rd_used;
		logic merge_more;
		logic buddy_ok;
	} dp_status_t;

	// Controller states.
	typedef enum logic [3:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_DISPATCH,
		CS_SCAN,
		CS_SPLIT,
		CS_MARK,
		CS_DIV,
		CS_DIV_CHECK,
		CS_PAGE_READ,
		CS_PAGE_CHECK,
		CS_MERGE_TEST,
		CS_MERGE_CHECK,
		CS_FREE_WRITE,
		CS_RESP
	} ctl_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
	parameter int unsigned WIDTH = 5,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_regs.sv =====
// ----------------------------------------------------------------------------
// bfa_regs
// Configuration registers behind the APB-style port: region base address
// and frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_regs
	import bfa_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [PADDR_W-1:0]       paddr,
	input  wire logic [31:0]              pwdata,
	output logic      [31:0]              prdata,
	output logic                          pready,
	output logic      [31:0]              base_address,
	output logic      [FRAME_BYTES_W-1:0] frame_bytes
);

	logic                     wr_en;
	reg_idx_t                 idx;
	logic [31:0]              base_q;
	logic [FRAME_BYTES_W-1:0] fbytes_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			fbytes_q <= FRAME_BYTES_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_BASE_ADDRESS: base_q   <= pwdata;
				REG_FRAME_BYTES:  fbytes_q <= pwdata[FRAME_BYTES_W-1:0];
				default:          base_q   <= base_q;
			endcase
		end
	end

	// Read data.
	always_comb begin
		unique case (idx)
			REG_BASE_ADDRESS: prdata = base_q;
			REG_FRAME_BYTES:  prdata = 32'(fbytes_q);
			default:          prdata = '0;
		endcase
	end

	assign base_address = base_q;
	assign frame_bytes  = fbytes_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl
// Controller of the allocator: sequences the table clear, the allocate scan
// and split, the free address check and merge, and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl
	import bfa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output dp_cmd_t         cmd,
	input  wire dp_status_t stat
);

	ctl_state_t state_q, state_d;
	status_t    code_q, code_d;
	logic       rsp_valid_q;

	// State, result code and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_CLEAR;
			code_q      <= ST_ALLOCATED;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (cmd.op == DP_RESULT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d   = state_q;
		code_d    = code_q;
		cmd.op    = DP_NOP;
		cmd.code  = code_q;
		req_ready = 1'b0;
		unique case (state_q)
			CS_CLEAR: begin
				cmd.op = DP_CLEAR_STEP;
				if (stat.clear_done) begin
					state_d = CS_IDLE;
				end
			end
			CS_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = DP_LOAD;
					state_d = CS_DISPATCH;
				end
			end
			CS_DISPATCH: begin
				if (stat.kind == KIND_FREE) begin
					state_d = CS_DIV;
				end else if (stat.too_large) begin
					code_d  = ST_TOO_LARGE;
					state_d = CS_RESP;
				end else begin
					state_d = CS_SCAN;
				end
			end
			CS_SCAN: begin
				cmd.op = DP_SCAN_STEP;
				if (stat.scan_hit) begin
					state_d = CS_SPLIT;
				end else if (stat.scan_empty) begin
					code_d  = ST_NO_FREE;
					state_d = CS_RESP;
				end
			end
			CS_SPLIT: begin
				if (stat.split_done) begin
					state_d = CS_MARK;
				end else begin
					cmd.op = DP_SPLIT_STEP;
				end
			end
			CS_MARK: begin
				cmd.op  = DP_MARK;
				code_d  = ST_ALLOCATED;
				state_d = CS_RESP;
			end
			CS_DIV: begin
				cmd.op = DP_DIV_STEP;
				if (stat.div_last) begin
					state_d = CS_DIV_CHECK;
				end
			end
			CS_DIV_CHECK: begin
				if (stat.div_bad) begin
					code_d  = ST_BAD_ADDRESS;
					state_d = CS_RESP;
				end else begin
					state_d = CS_PAGE_READ;
				end
			end
			CS_PAGE_READ: begin
				cmd.op  = DP_PAGE_READ;
				state_d = CS_PAGE_CHECK;
			end
			CS_PAGE_CHECK: begin
				if (!stat.rd_used) begin
					code_d  = ST_BAD_ADDRESS;
					state_d = CS_RESP;
				end else begin
					cmd.op  = DP_PAGE_TAKE;
					state_d = CS_MERGE_TEST;
				end
			end
			CS_MERGE_TEST: begin
				if (stat.merge_more) begin
					cmd.op  = DP_BUDDY_READ;
					state_d = CS_MERGE_CHECK;
				end else begin
					state_d = CS_FREE_WRITE;
				end
			end
			CS_MERGE_CHECK: begin
				if (stat.buddy_ok) begin
					cmd.op  = DP_MERGE;
					state_d = CS_MERGE_TEST;
				end else begin
					state_d = CS_FREE_WRITE;
				end
			end
			CS_FREE_WRITE: begin
				cmd.op  = DP_FREE_WRITE;
				code_d  = ST_FREED;
				state_d = CS_RESP;
			end
			CS_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.op  = DP_RESULT;
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_datapath.sv =====
// ----------------------------------------------------------------------------
// bfa_datapath
// Block table memory with its scan pipeline, split and merge address logic,
// the restoring divider that turns a free address into a frame index, and
// the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_datapath
	import bfa_pkg::*;
#(
	parameter int unsigned LOG2_FRAMES = 10
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dp_cmd_t                  cmd,
	output dp_status_t                    stat,
	input  wire in_word_t                 req,
	input  wire logic [31:0]              base_address,
	input  wire logic [FRAME_BYTES_W-1:0] frame_bytes,
	output out_word_t                     rsp
);

	localparam int unsigned AW    = LOG2_FRAMES;
	localparam int unsigned LW    = $clog2(LOG2_FRAMES + 1);
	localparam int unsigned EW    = LW + 1;
	localparam int unsigned DEPTH = 1 << LOG2_FRAMES;
	localparam int unsigned DW    = (LOG2_FRAMES > 15) ? (FRAME_BYTES_W + LOG2_FRAMES) : 32;
	localparam logic [LW-1:0] MAXL = LW'(LOG2_FRAMES);

	// Frames covered by a block at a given level, one bit wider than an index.
	function automatic logic [AW:0] span_of(input logic [LW-1:0] l);
		return (AW + 1)'(1) << (MAXL - l);
	endfunction

	// Ceiling of log2 of the frame count, with zero taken as one.
	function automatic logic [4:0] ceil_log2(input logic [15:0] n);
		logic [15:0] m;
		logic [4:0]  k;
		m = (n == 16'd0) ? 16'd0 : n - 16'd1;
		k = '0;
		for (int b = 0; b < 16; b++) begin
			if (m[b]) begin
				k = 5'(b + 1);
			end
		end
		return k;
	endfunction

	// Low ten bits of a frame index.
	function automatic logic [9:0] idx10(input logic [AW-1:0] v);
		logic [AW+9:0] w;
		w = (AW + 10)'(v);
		return w[9:0];
	endfunction

	// Table memory ports.
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;
	logic          rd_used;
	logic [LW-1:0] rd_lvl;

	// Request and scan state.
	logic          kind_q, too_large_q;
	logic [LW-1:0] tgt_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] sidx_q, idx_s1, fidx_q;
	logic [LW-1:0] slvl_q, lvl_s1, flvl_q;
	logic          slive_q, vld_s1;
	logic [AW:0]   scan_span, scan_next, split_span, merge_span;
	logic [LW-1:0] split_lvl;
	logic [4:0]    req_k;
	logic          hit;

	// Divider and merge state.
	logic [DW-1:0] rem_q, div_d;
	logic [LW-1:0] dbit_q;
	logic          bad_q;
	logic [AW-1:0] page_q, first_q, buddy, merge_hi, merge_lo;
	logic [LW-1:0] mlvl_q;
	logic [FRAME_BYTES_W-1:0] fb_div;
	logic          div_ge;
	logic [31:0]   prod_q;
	out_word_t     rsp_q;

	bfa_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rd_used = mem_rdata[LW];
	assign rd_lvl  = mem_rdata[LW-1:0];

	// Address arithmetic for scan, split and merge.
	assign req_k      = ceil_log2(req.frames_wanted);
	assign scan_span  = span_of(slvl_q);
	assign scan_next  = {1'b0, sidx_q} + scan_span;
	assign split_lvl  = flvl_q + LW'(1);
	assign split_span = span_of(split_lvl);
	assign merge_span = span_of(mlvl_q);
	assign buddy      = page_q ^ merge_span[AW-1:0];
	assign merge_hi   = (buddy > page_q) ? buddy : page_q;
	assign merge_lo   = (buddy > page_q) ? page_q : buddy;
	assign hit        = vld_s1 && !rd_used && (rd_lvl == lvl_s1);

	// Divider step: compare the remainder with the frame size shifted up.
	assign fb_div = (frame_bytes == '0) ? FRAME_BYTES_W'(1) : frame_bytes;
	assign div_d  = DW'(fb_div) << dbit_q;
	assign div_ge = rem_q >= div_d;

	// Memory port selection per command.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fidx_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = sidx_q;
		case (cmd.op)
			DP_CLEAR_STEP: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			DP_SCAN_STEP: begin
				mem_re = slive_q;
			end
			DP_SPLIT_STEP: begin
				mem_we    = 1'b1;
				mem_waddr = fidx_q + split_span[AW-1:0];
				mem_wdata = {1'b0, split_lvl};
			end
			DP_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, tgt_q};
			end
			DP_PAGE_READ: begin
				mem_re    = 1'b1;
				mem_raddr = page_q;
			end
			DP_BUDDY_READ: begin
				mem_re    = 1'b1;
				mem_raddr = buddy;
			end
			DP_MERGE: begin
				mem_we    = 1'b1;
				mem_waddr = merge_hi;
			end
			DP_FREE_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = page_q;
				mem_wdata = {1'b0, mlvl_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Control registers: clear counter and scan pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			slive_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			case (cmd.op)
				DP_CLEAR_STEP: begin
					clr_q <= clr_q + AW'(1);
				end
				DP_LOAD: begin
					slive_q <= 1'b1;
					vld_s1  <= 1'b0;
				end
				DP_SCAN_STEP: begin
					vld_s1 <= slive_q;
					if (slive_q && scan_next[AW] && slvl_q == '0) begin
						slive_q <= 1'b0;
					end
				end
				default: begin
					vld_s1 <= vld_s1;
				end
			endcase
		end
	end

	// Payload registers of every phase.
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				kind_q      <= req.kind;
				too_large_q <= req_k > 5'(LOG2_FRAMES);
				tgt_q       <= MAXL - req_k[LW-1:0];
				slvl_q      <= MAXL - req_k[LW-1:0];
				sidx_q      <= '0;
				rem_q       <= DW'(req.free_address - base_address);
				dbit_q      <= MAXL;
				bad_q       <= 1'b0;
				page_q      <= '0;
			end
			DP_SCAN_STEP: begin
				// Walk the heads of one level, then move one level up.
				idx_s1 <= sidx_q;
				lvl_s1 <= slvl_q;
				if (slive_q) begin
					if (scan_next[AW]) begin
						sidx_q <= '0;
						if (slvl_q != '0) begin
							slvl_q <= slvl_q - LW'(1);
						end
					end else begin
						sidx_q <= scan_next[AW-1:0];
					end
				end
				if (hit) begin
					fidx_q <= idx_s1;
					flvl_q <= lvl_s1;
				end
			end
			DP_SPLIT_STEP: begin
				flvl_q <= split_lvl;
			end
			DP_MARK: begin
				prod_q <= 32'(frame_bytes) * 32'(fidx_q);
			end
			DP_DIV_STEP: begin
				// The top step only checks that the offset is inside the region.
				if (dbit_q == MAXL) begin
					if (div_ge) begin
						bad_q <= 1'b1;
					end
				end else if (div_ge) begin
					rem_q  <= rem_q - div_d;
					page_q <= page_q | (AW'(1) << dbit_q);
				end
				if (dbit_q != '0) begin
					dbit_q <= dbit_q - LW'(1);
				end
			end
			DP_PAGE_TAKE: begin
				first_q <= page_q;
				mlvl_q  <= (rd_lvl > MAXL) ? MAXL : rd_lvl;
			end
			DP_MERGE: begin
				page_q <= merge_lo;
				mlvl_q <= mlvl_q - LW'(1);
			end
			DP_RESULT: begin
				rsp_q.status <= cmd.code;
				if (cmd.code == ST_ALLOCATED) begin
					rsp_q.block_address <= base_address + prod_q;
					rsp_q.frame_index   <= idx10(fidx_q);
				end else if (cmd.code == ST_FREED) begin
					rsp_q.block_address <= '0;
					rsp_q.frame_index   <= idx10(first_q);
				end else begin
					rsp_q.block_address <= '0;
					rsp_q.frame_index   <= '0;
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

	// Status toward the controller.
	always_comb begin
		stat.kind       = kind_q;
		stat.too_large  = too_large_q;
		stat.clear_done = &clr_q;
		stat.scan_hit   = hit;
		stat.scan_empty = !vld_s1 && !slive_q;
		stat.split_done = flvl_q == tgt_q;
		stat.div_last   = dbit_q == '0;
		stat.div_bad    = bad_q || (rem_q != '0);
		stat.rd_used    = rd_used;
		stat.merge_more = mlvl_q != '0;
		stat.buddy_ok   = !rd_used && (rd_lvl == mlvl_q);
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/buddy_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// buddy_frame_allocator_top
// Buddy allocator over 2^LOG2_FRAMES frames with a block table in memory.
//
// Usage: a request word (req, req_valid/req_ready) either allocates a
// power-of-two run of frames or frees a block by byte address. Each request
// yields one result word (rsp, rsp_valid/rsp_ready) with the block address,
// the first frame index and a status code. Base address and frame size are
// to be set over the APB-style port only while the block is idle; the block
// itself does not enforce this. One request is worked on at a time. The
// table scan of an allocate reads one block head per cycle through the
// single memory read port. A free is paced by the one-bit-a-step address
// divider and one memory read per buddy.
// After reset a clearing pass writes every table entry, and req_ready stays
// low until it ends; configuration writes are taken. A finished result
// sits in the output register while the next request is accepted; if the
// receiver stalls, that next result waits until the output register is
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_frame_allocator_top
	import bfa_pkg::*;
#(
	parameter int unsigned LOG2_FRAMES = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire in_word_t           req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output out_word_t               rsp
);

	logic [31:0]              base_address;
	logic [FRAME_BYTES_W-1:0] frame_bytes;
	dp_cmd_t                  cmd;
	dp_status_t               stat;

	// Configuration registers.
	bfa_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.base_address (base_address),
		.frame_bytes  (frame_bytes)
	);

	// Sequencing of each request.
	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Table, scan, divider and result word.
	bfa_datapath #(
		.LOG2_FRAMES (LOG2_FRAMES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req          (req),
		.base_address (base_address),
		.frame_bytes  (frame_bytes),
		.rsp          (rsp)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_checker.sv =====
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the buddy frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_checker
	import bfa_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_ready,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire out_word_t rsp
);

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// Only one request is in work: no accept right after an accept.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	// Only a successful allocate carries a block address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_ALLOCATED |-> rsp.block_address == '0)
		else $error("block address set on a result that is not an allocate");

	// Error results carry frame index zero.
	a_err_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_NO_FREE || rsp.status == ST_TOO_LARGE
			|| rsp.status == ST_BAD_ADDRESS) |-> rsp.frame_index == '0)
		else $error("frame index set on an error result");

endmodule

bind buddy_frame_allocator_top bfa_checker u_bfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
